### sv/cwdp_pkg.sv
package cwdp_pkg;

   // field widths
   localparam int PIXEL_W      = 8;
   localparam int POS_CFG_W    = 10;
   localparam int SIDE_CFG_W   = 8;
   localparam int CHUNK_CFG_W  = 11;
   localparam int NUM_W        = 8;
   localparam int KEPT_W       = 15;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;
   localparam int REG_IDX_W    = 3;

   // parameter defaults
   localparam int MAX_LINE_WIDTH_DEF = 1024;
   localparam int MAX_OUT_SIDE_DEF   = 128;
   localparam int MAX_CHUNK_DEF      = 2048;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FIRST_ROW   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FIRST_COL   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OUT_COLS    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OUT_ROWS    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CHUNK_LEN   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_A      = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SYNC_B      = 3'd7;

   // register reset values
   localparam logic [POS_CFG_W-1:0]   LINE_WIDTH_RST = 10'd324;
   localparam logic [POS_CFG_W-1:0]   FIRST_ROW_RST  = 10'd26;
   localparam logic [POS_CFG_W-1:0]   FIRST_COL_RST  = 10'd67;
   localparam logic [SIDE_CFG_W-1:0]  OUT_COLS_RST   = 8'd96;
   localparam logic [SIDE_CFG_W-1:0]  OUT_ROWS_RST   = 8'd96;
   localparam logic [CHUNK_CFG_W-1:0] CHUNK_LEN_RST  = 11'd1400;
   localparam logic [PIXEL_W-1:0]     SYNC_A_RST     = 8'h55;
   localparam logic [PIXEL_W-1:0]     SYNC_B_RST     = 8'hAA;

   // output byte sequence of one packet start
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_SYNC_A = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC_B = 3'd1;
   localparam logic [STEP_W-1:0] STEP_FRAME  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_PACKET = 3'd3;
   localparam logic [STEP_W-1:0] STEP_PIXEL  = 3'd4;

   typedef struct packed {
      logic [POS_CFG_W-1:0]   line_width;
      logic [POS_CFG_W-1:0]   window_first_row;
      logic [POS_CFG_W-1:0]   window_first_col;
      logic [SIDE_CFG_W-1:0]  out_cols;
      logic [SIDE_CFG_W-1:0]  out_rows;
      logic [CHUNK_CFG_W-1:0] chunk_len;
      logic [PIXEL_W-1:0]     sync_byte_a;
      logic [PIXEL_W-1:0]     sync_byte_b;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last_of_packet;
      logic               last_of_frame;
      logic [NUM_W-1:0]   frame_num;
      logic [NUM_W-1:0]   packet_num;
   } item_type;

endpackage

### sv/cwdp_ifs.sv
interface cwdp_req_if
   import cwdp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, pixel, frame_start, input ready);
   modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface cwdp_rsp_if
   import cwdp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] data_byte;
   logic               is_header;
   logic               last_of_packet;
   logic               last_of_frame;

   modport source (output valid, data_byte, is_header, last_of_packet, last_of_frame,
                   input ready);
   modport sink   (input valid, data_byte, is_header, last_of_packet, last_of_frame,
                   output ready);
endinterface

### sv/cwdp_csr.sv
module cwdp_csr
   import cwdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [REG_IDX_W-1:0] idx;
   logic wr_en;

   assign idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_LINE_WIDTH: cfg_in.line_width       = pwdata[POS_CFG_W-1:0];
            REG_FIRST_ROW:  cfg_in.window_first_row = pwdata[POS_CFG_W-1:0];
            REG_FIRST_COL:  cfg_in.window_first_col = pwdata[POS_CFG_W-1:0];
            REG_OUT_COLS:   cfg_in.out_cols         = pwdata[SIDE_CFG_W-1:0];
            REG_OUT_ROWS:   cfg_in.out_rows         = pwdata[SIDE_CFG_W-1:0];
            REG_CHUNK_LEN:  cfg_in.chunk_len        = pwdata[CHUNK_CFG_W-1:0];
            REG_SYNC_A:     cfg_in.sync_byte_a      = pwdata[PIXEL_W-1:0];
            REG_SYNC_B:     cfg_in.sync_byte_b      = pwdata[PIXEL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width       <= LINE_WIDTH_RST;
         cfg_ff.window_first_row <= FIRST_ROW_RST;
         cfg_ff.window_first_col <= FIRST_COL_RST;
         cfg_ff.out_cols         <= OUT_COLS_RST;
         cfg_ff.out_rows         <= OUT_ROWS_RST;
         cfg_ff.chunk_len        <= CHUNK_LEN_RST;
         cfg_ff.sync_byte_a      <= SYNC_A_RST;
         cfg_ff.sync_byte_b      <= SYNC_B_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_LINE_WIDTH: prdata = CSR_DATA_W'(cfg_ff.line_width);
         REG_FIRST_ROW:  prdata = CSR_DATA_W'(cfg_ff.window_first_row);
         REG_FIRST_COL:  prdata = CSR_DATA_W'(cfg_ff.window_first_col);
         REG_OUT_COLS:   prdata = CSR_DATA_W'(cfg_ff.out_cols);
         REG_OUT_ROWS:   prdata = CSR_DATA_W'(cfg_ff.out_rows);
         REG_CHUNK_LEN:  prdata = CSR_DATA_W'(cfg_ff.chunk_len);
         REG_SYNC_A:     prdata = CSR_DATA_W'(cfg_ff.sync_byte_a);
         REG_SYNC_B:     prdata = CSR_DATA_W'(cfg_ff.sync_byte_b);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### sv/camera_window_decimate_packetizer.sv
// path: a kept pixel taken on req passes the input register, then the output register, before
// its first word is on rsp; when the pixel opens a packet its own word follows the headers
// throughput: one pixel word per cycle while rsp is ready; a kept pixel that opens a packet
// holds the output register for four header words, then the pixel word
// reset (synchronous, active high) restores the register defaults and clears all
// counters; pixels are dropped until the first frame_start
module camera_window_decimate_packetizer
   import cwdp_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
   parameter int MAX_OUT_SIDE   = MAX_OUT_SIDE_DEF,
   parameter int MAX_CHUNK      = MAX_CHUNK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cwdp_req_if.sink              req_chan,
   cwdp_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int PW   = $clog2(MAX_LINE_WIDTH);
   localparam int AW   = ((PW > POS_CFG_W) ? PW : POS_CFG_W) + 1;
   localparam int OW   = $clog2(MAX_OUT_SIDE + 1);
   localparam int OCW  = (OW > SIDE_CFG_W) ? OW : SIDE_CFG_W;
   localparam int TW   = 2 * OCW;
   localparam int KCW  = (TW > KEPT_W + 1) ? TW : KEPT_W + 1;
   localparam int WW   = ((AW > OCW) ? AW : OCW) + 1;
   localparam int FW   = $clog2(MAX_CHUNK);
   localparam int CW0  = $clog2(MAX_CHUNK + 1);
   localparam int CLW  = (CW0 > CHUNK_CFG_W) ? CW0 : CHUNK_CFG_W;

   cfg_type cfg;

   cwdp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] in_pixel_ff;
   logic               in_fs_ff;

   // frame state
   logic [PW-1:0]     row_ff, row_in;
   logic [PW-1:0]     col_ff, col_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [NUM_W-1:0]  pkt_num_ff, pkt_num_in;
   logic [NUM_W-1:0]  frame_num_ff, frame_num_in;
   logic              in_frame_ff, in_frame_in;

   // output register and header sequencer
   logic              out_valid_ff, out_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   item_type          item_ff, item_in;

   // effective config
   logic [AW-1:0]  lw;
   logic [OCW-1:0] oc, orows;
   logic [TW-1:0]  total;
   logic [CLW-1:0] cl;

   always_comb begin
      lw = AW'(cfg.line_width);
      if (lw == '0) begin
         lw = AW'(1);
      end else if (lw > AW'(MAX_LINE_WIDTH)) begin
         lw = AW'(MAX_LINE_WIDTH);
      end
      oc = OCW'(cfg.out_cols);
      if (oc > OCW'(MAX_OUT_SIDE)) begin
         oc = OCW'(MAX_OUT_SIDE);
      end
      orows = OCW'(cfg.out_rows);
      if (orows > OCW'(MAX_OUT_SIDE)) begin
         orows = OCW'(MAX_OUT_SIDE);
      end
      cl = CLW'(cfg.chunk_len);
      if (cl == '0) begin
         cl = CLW'(1);
      end else if (cl > CLW'(MAX_CHUNK)) begin
         cl = CLW'(MAX_CHUNK);
      end
   end

   assign total = TW'(oc) * TW'(orows);

   // state as seen by the word in the input register (frame start restarts it)
   logic [PW-1:0]     row_cur, col_cur;
   logic [KEPT_W-1:0] kept_cur;
   logic [FW-1:0]     fill_cur;
   logic [NUM_W-1:0]  pkt_cur, frame_cur;
   logic              live;

   assign row_cur   = in_fs_ff ? '0 : row_ff;
   assign col_cur   = in_fs_ff ? '0 : col_ff;
   assign kept_cur  = in_fs_ff ? '0 : kept_ff;
   assign fill_cur  = in_fs_ff ? '0 : fill_ff;
   assign pkt_cur   = in_fs_ff ? '0 : pkt_num_ff;
   assign frame_cur = in_fs_ff ? frame_num_ff + NUM_W'(1) : frame_num_ff;
   assign live      = in_fs_ff || in_frame_ff;

   // window test: pos >= first, even distance, half distance below count
   logic [WW-1:0] row_d, col_d;
   logic          row_hit, col_hit;

   assign row_d   = WW'(row_cur) - WW'(cfg.window_first_row);
   assign col_d   = WW'(col_cur) - WW'(cfg.window_first_col);
   assign row_hit = (WW'(row_cur) >= WW'(cfg.window_first_row)) && !row_d[0]
                    && ((row_d >> 1) < WW'(orows));
   assign col_hit = (WW'(col_cur) >= WW'(cfg.window_first_col)) && !col_d[0]
                    && ((col_d >> 1) < WW'(oc));

   logic [KCW-1:0] kept_ext;
   logic           full, keep, line_end, last_frame, last_pkt;

   assign kept_ext   = KCW'(kept_cur);
   assign full       = kept_ext >= KCW'(total);
   assign keep       = live && !full && row_hit && col_hit;
   assign line_end   = (AW'(col_cur) + AW'(1)) >= lw;
   assign last_frame = (kept_ext + KCW'(1)) == KCW'(total);
   assign last_pkt   = ((CLW'(fill_cur) + CLW'(1)) >= cl) || last_frame;

   // handshakes
   logic emit_free, advance, load, out_done;

   assign out_done  = rsp_chan.ready && (step_ff == STEP_PIXEL);
   assign emit_free = !out_valid_ff || out_done;
   assign advance   = in_valid_ff && (!keep || emit_free);
   assign load      = in_valid_ff && keep && emit_free;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      kept_in      = kept_ff;
      fill_in      = fill_ff;
      pkt_num_in   = pkt_num_ff;
      frame_num_in = frame_num_ff;
      in_frame_in  = in_frame_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         frame_num_in = frame_cur;
         in_frame_in  = live;
         if (live) begin
            row_in     = row_cur;
            kept_in    = kept_cur;
            fill_in    = fill_cur;
            pkt_num_in = pkt_cur;
            if (line_end) begin
               col_in = '0;
               // row saturates at the last line position
               if (row_cur < PW'(MAX_LINE_WIDTH - 1)) begin
                  row_in = row_cur + PW'(1);
               end
            end else begin
               col_in = col_cur + PW'(1);
            end
            if (keep) begin
               kept_in = kept_cur + KEPT_W'(1);
               if (last_pkt) begin
                  fill_in    = '0;
                  pkt_num_in = pkt_cur + NUM_W'(1);
               end else begin
                  fill_in = fill_cur + FW'(1);
               end
            end
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      step_in      = step_ff;
      item_in      = item_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         if (step_ff == STEP_PIXEL) begin
            out_valid_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
      if (load) begin
         out_valid_in           = 1'b1;
         step_in                = (fill_cur == '0) ? STEP_SYNC_A : STEP_PIXEL;
         item_in.pixel          = in_pixel_ff;
         item_in.last_of_packet = last_pkt;
         item_in.last_of_frame  = last_frame;
         item_in.frame_num      = frame_cur;
         item_in.packet_num     = pkt_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         kept_ff      <= '0;
         fill_ff      <= '0;
         pkt_num_ff   <= '0;
         frame_num_ff <= '0;
         in_frame_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= STEP_PIXEL;
      end else begin
         in_valid_ff  <= in_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         kept_ff      <= kept_in;
         fill_ff      <= fill_in;
         pkt_num_ff   <= pkt_num_in;
         frame_num_ff <= frame_num_in;
         in_frame_ff  <= in_frame_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_pixel_ff <= req_chan.pixel;
         in_fs_ff    <= req_chan.frame_start;
      end
      item_ff <= item_in;
   end

   // output word mux
   always_comb begin
      case (step_ff)
         STEP_SYNC_A: rsp_chan.data_byte = cfg.sync_byte_a;
         STEP_SYNC_B: rsp_chan.data_byte = cfg.sync_byte_b;
         STEP_FRAME:  rsp_chan.data_byte = item_ff.frame_num;
         STEP_PACKET: rsp_chan.data_byte = item_ff.packet_num;
         default:     rsp_chan.data_byte = item_ff.pixel;
      endcase
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.is_header      = (step_ff != STEP_PIXEL);
   assign rsp_chan.last_of_packet = (step_ff == STEP_PIXEL) && item_ff.last_of_packet;
   assign rsp_chan.last_of_frame  = (step_ff == STEP_PIXEL) && item_ff.last_of_frame;

endmodule

### sv/cwdp_checker.sv
module cwdp_checker
   import cwdp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIXEL_W-1:0] rsp_data_byte,
   input logic               rsp_is_header,
   input logic               rsp_last_of_packet,
   input logic               rsp_last_of_frame,
   input logic               pready
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_is_header) && $stable(rsp_last_of_packet))
      else $error("rsp word changed while stalled");

   // header words come back to back up to the pixel word
   a_hdr_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_header |=> rsp_valid)
      else $error("header not followed by a word");

   // end of window always closes the packet and is a pixel word
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_packet && !rsp_is_header)
      else $error("last_of_frame without last_of_packet");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && pready)
      else $error("output valid right after reset");

endmodule

bind camera_window_decimate_packetizer cwdp_checker u_cwdp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_data_byte      (rsp_chan.data_byte),
   .rsp_is_header      (rsp_chan.is_header),
   .rsp_last_of_packet (rsp_chan.last_of_packet),
   .rsp_last_of_frame  (rsp_chan.last_of_frame),
   .pready             (pready)
);

### sim/cwdp_packet_checker.sv
`timescale 1ns / 100ps

module cwdp_packet_checker
   import cwdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cwdp_req_if                   req_mon,
   cwdp_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    words_outstanding,
   output int                    words_checked
);

   typedef struct packed {
      logic [PIXEL_W-1:0] data_byte;
      logic               is_header;
      logic               last_of_packet;
      logic               last_of_frame;
   } packet_word_type;

   packet_word_type expected_words[$];

   cfg_type                shadow_cfg;
   logic [POS_CFG_W-1:0]   row_pos;
   logic [POS_CFG_W-1:0]   col_pos;
   logic [KEPT_W-1:0]      kept_pixels;
   logic [CHUNK_CFG_W-1:0] packet_bytes;
   logic [NUM_W-1:0]       packet_idx;
   logic [NUM_W-1:0]       frame_idx;
   logic                   frame_open;

   function automatic int limit(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit window_hit(input int pos, input int first, input int count);
      int d;
      if (pos < first) return 0;
      d = pos - first;
      if (d % 2 != 0) return 0;
      return (d / 2) < count;
   endfunction

   task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_LINE_WIDTH: shadow_cfg.line_width       = v[POS_CFG_W-1:0];
         REG_FIRST_ROW:  shadow_cfg.window_first_row = v[POS_CFG_W-1:0];
         REG_FIRST_COL:  shadow_cfg.window_first_col = v[POS_CFG_W-1:0];
         REG_OUT_COLS:   shadow_cfg.out_cols         = v[SIDE_CFG_W-1:0];
         REG_OUT_ROWS:   shadow_cfg.out_rows         = v[SIDE_CFG_W-1:0];
         REG_CHUNK_LEN:  shadow_cfg.chunk_len        = v[CHUNK_CFG_W-1:0];
         REG_SYNC_A:     shadow_cfg.sync_byte_a      = v[PIXEL_W-1:0];
         REG_SYNC_B:     shadow_cfg.sync_byte_b      = v[PIXEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_word(input logic [PIXEL_W-1:0] b, input logic hdr,
                            input logic lp, input logic lf);
      packet_word_type w;
      w.data_byte      = b;
      w.is_header      = hdr;
      w.last_of_packet = lp;
      w.last_of_frame  = lf;
      expected_words.push_back(w);
   endtask

   // works out the packet words that one sensor pixel causes
   task automatic packetize_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      int lw, oc, orows, cl, total, r, c;
      logic lf, lp;
      lw    = limit(int'(shadow_cfg.line_width), 1, MAX_LINE_WIDTH_DEF);
      oc    = limit(int'(shadow_cfg.out_cols), 0, MAX_OUT_SIDE_DEF);
      orows = limit(int'(shadow_cfg.out_rows), 0, MAX_OUT_SIDE_DEF);
      cl    = limit(int'(shadow_cfg.chunk_len), 1, MAX_CHUNK_DEF);
      total = oc * orows;
      if (fs) begin
         frame_open   = 1'b1;
         row_pos      = '0;
         col_pos      = '0;
         kept_pixels  = '0;
         packet_bytes = '0;
         packet_idx   = '0;
         frame_idx    = frame_idx + 1'b1;
      end
      if (!frame_open) return;
      r = int'(row_pos);
      c = int'(col_pos);
      if (c + 1 >= lw) begin
         col_pos = '0;
         // row counter sticks at the top instead of wrapping
         if (r < MAX_LINE_WIDTH_DEF - 1) row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      if (int'(kept_pixels) >= total) return;
      if (!window_hit(r, int'(shadow_cfg.window_first_row), orows)) return;
      if (!window_hit(c, int'(shadow_cfg.window_first_col), oc)) return;
      if (packet_bytes == 0) begin
         push_word(shadow_cfg.sync_byte_a, 1'b1, 1'b0, 1'b0);
         push_word(shadow_cfg.sync_byte_b, 1'b1, 1'b0, 1'b0);
         push_word(frame_idx, 1'b1, 1'b0, 1'b0);
         push_word(packet_idx, 1'b1, 1'b0, 1'b0);
      end
      lf = (int'(kept_pixels) + 1 == total);
      lp = (int'(packet_bytes) + 1 >= cl) || lf;
      push_word(pix, 1'b0, lp, lf);
      kept_pixels = kept_pixels + 1'b1;
      if (lp) begin
         packet_bytes = '0;
         packet_idx   = packet_idx + 1'b1;
      end else begin
         packet_bytes = packet_bytes + 1'b1;
      end
   endtask

   task automatic flag(input string field, input int want, input int got);
      if (fail_count < 50) $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      packet_word_type want;
      if (reset) begin
         shadow_cfg.line_width       = LINE_WIDTH_RST;
         shadow_cfg.window_first_row = FIRST_ROW_RST;
         shadow_cfg.window_first_col = FIRST_COL_RST;
         shadow_cfg.out_cols         = OUT_COLS_RST;
         shadow_cfg.out_rows         = OUT_ROWS_RST;
         shadow_cfg.chunk_len        = CHUNK_LEN_RST;
         shadow_cfg.sync_byte_a      = SYNC_A_RST;
         shadow_cfg.sync_byte_b      = SYNC_B_RST;
         row_pos       = '0;
         col_pos       = '0;
         kept_pixels   = '0;
         packet_bytes  = '0;
         packet_idx    = '0;
         frame_idx     = '0;
         frame_open    = 1'b0;
         fail_count    = 0;
         words_checked = 0;
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            write_register(paddr[CSR_ADDR_W-1:2], pwdata);
         if (req_mon.valid && req_mon.ready)
            packetize_pixel(req_mon.pixel, req_mon.frame_start);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               flag("unexpected word, data_byte", -1, int'(rsp_mon.data_byte));
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (rsp_mon.data_byte !== want.data_byte)
                  flag("data_byte", int'(want.data_byte), int'(rsp_mon.data_byte));
               if (rsp_mon.is_header !== want.is_header)
                  flag("is_header", int'(want.is_header), int'(rsp_mon.is_header));
               if (rsp_mon.last_of_packet !== want.last_of_packet)
                  flag("last_of_packet", int'(want.last_of_packet),
                       int'(rsp_mon.last_of_packet));
               if (rsp_mon.last_of_frame !== want.last_of_frame)
                  flag("last_of_frame", int'(want.last_of_frame),
                       int'(rsp_mon.last_of_frame));
            end
         end
      end
      words_outstanding <= expected_words.size();
   end

endmodule

### sim/camera_window_decimate_packetizer_tb.sv
`timescale 1ns / 100ps

module camera_window_decimate_packetizer_tb;
   import cwdp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int words_outstanding;
   int words_checked;
   int words_sent     = 0;
   int frames_started = 0;
   int settings_used  = 0;
   bit steady         = 1'b0;

   cwdp_req_if req_bus ();
   cwdp_rsp_if rsp_bus ();

   camera_window_decimate_packetizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   cwdp_packet_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .words_outstanding (words_outstanding),
      .words_checked     (words_checked)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: ready runs of random length, mostly short stalls, now and then long ones
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 12)) @(posedge clock);
         rsp_bus.ready <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 30)) @(posedge clock);
         else repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   end

   function automatic int idle_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [PIXEL_W-1:0] corner_pixel(input int i);
      case (i % 3)
         0:       return PIXEL_W'($urandom_range(0, 255));
         1:       return 8'hFF;
         default: return 8'h00;
      endcase
   endfunction

   task automatic send_word(input logic [PIXEL_W-1:0] pix, input logic fs);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= pix;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (fs) frames_started++;
   endtask

   // waits until every expected word is out, then lets the pipeline settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input int lw, input int fr, input int fc, input int oc,
                            input int orows, input int cl, input int sa, input int sb);
      drain();
      csr_write(REG_LINE_WIDTH, lw);
      csr_write(REG_FIRST_ROW, fr);
      csr_write(REG_FIRST_COL, fc);
      csr_write(REG_OUT_COLS, oc);
      csr_write(REG_OUT_ROWS, orows);
      csr_write(REG_CHUNK_LEN, cl);
      csr_write(REG_SYNC_A, sa);
      csr_write(REG_SYNC_B, sb);
      settings_used++;
   endtask

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++) send_word(PIXEL_W'($urandom_range(0, 255)), i == 0);
   endtask

   initial begin
      int lw, fr, fc, oc, orows, len, random_words;
      req_bus.valid       = 1'b0;
      req_bus.pixel       = '0;
      req_bus.frame_start = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no frame seen yet, these words are dropped
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(PIXEL_W'($urandom_range(0, 255)), 1'b0);
      drain();

      // 2x2 window in a 4-wide line, default sync bytes and chunk length
      csr_write(REG_LINE_WIDTH, 4);
      csr_write(REG_FIRST_ROW, 1);
      csr_write(REG_FIRST_COL, 1);
      csr_write(REG_OUT_COLS, 2);
      csr_write(REG_OUT_ROWS, 2);
      settings_used++;
      // first frame cut short by a new frame start, second one runs past completion
      for (int i = 0; i < 9; i++) send_word(corner_pixel(i), i == 0);
      for (int i = 0; i < 18; i++) send_word(corner_pixel(i), i == 0);

      // every word a frame start, one-byte packets
      configure(2, 0, 0, 1, 1, 1, 8'h00, 8'hFF);
      repeat (20) send_word(PIXEL_W'($urandom_range(0, 255)), 1'b1);

      // one pixel per line, out_rows above the clamp
      configure(1, 0, 0, 1, 255, 1468, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(30);

      // wide line, out_cols above the clamp, largest chunk length
      configure(300, 0, 0, 255, 1, 2047, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(20);

      // empty windows
      configure(8, 0, 0, 0, 5, 3, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(10);
      configure(8, 0, 0, 5, 0, 3, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(10);

      // window beyond the line and frame, never reached
      configure(8, 1023, 1023, 4, 4, 2, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(10);

      // zero chunk length: every pixel its own packet
      configure(6, 0, 0, 3, 90, 0, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(24);

      // zero line width: every word ends a line
      configure(0, 5, 0, 2, 1, 2, $urandom_range(0, 255), $urandom_range(0, 255));
      send_frame(10);

      // random small windows, mostly whole frames, some cut short or with stray frame starts
      random_words = 0;
      while (random_words < 70) begin
         lw    = $urandom_range(2, 10);
         fr    = $urandom_range(0, 3);
         fc    = $urandom_range(0, lw - 1);
         oc    = $urandom_range(1, 3);
         orows = $urandom_range(1, 3);
         configure(lw, fr, fc, oc, orows, $urandom_range(1, 5),
                   $urandom_range(0, 255), $urandom_range(0, 255));
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            len = lw * (fr + 2 * orows) + $urandom_range(0, 4);
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
            for (int i = 0; (i < len) && (random_words < 70); i++) begin
               send_word(PIXEL_W'($urandom_range(0, 255)),
                         (i == 0) || ($urandom_range(0, 49) == 0));
               random_words++;
               if ($urandom_range(0, 99) == 0) drain();
            end
         end
         steady = 1'b0;
      end

      drain();
      $display("run covered %0d pixel words, %0d frame starts, %0d register settings",
               words_sent, frames_started, settings_used);
      $display("%0d packet words checked", words_checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
